[rtl/core/assert_macros.svh]
// assertion helpers for the ellipse rasterizer core
// each macro samples on the rising edge of clock and is disabled while reset is high
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLY(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/core/mer_pkg.sv]
// shared codes for the midpoint ellipse rasterizer core
// used by mer_seq, mer_emit and the top level; no dependencies
`timescale 1ns / 1ps

package mer_pkg;

   // request operation codes
   localparam logic OP_START   = 1'b0;
   localparam logic OP_ADVANCE = 1'b1;

   // pixel colors
   localparam logic COLOR_WHITE = 1'b0;
   localparam logic COLOR_GREEN = 1'b1;

   // eight mirrored pixels per point
   localparam int          PIX_CNT_W    = 3;
   localparam logic [2:0]  PIX_LAST_IDX = 3'd7;

endpackage

[rtl/core/mer_mul.sv]
// shared signed multiplier with a registered product
// no package dependencies; instantiated by mer_seq
`timescale 1ns / 1ps

module mer_mul #(
   parameter int W = 23
) (
   input  logic                  clock,
   input  logic signed [W-1:0]   mul_a,
   input  logic signed [W-1:0]   mul_b,
   output logic signed [2*W-1:0] prod
);

   logic signed [2*W-1:0] prod_ff;

   always_ff @(posedge clock) begin
      prod_ff <= mul_a * mul_b;
   end

   assign prod = prod_ff;

endmodule

[rtl/core/mer_emit.sv]
// pixel emitter: holds center and translated center, walks the eight mirrored pixels
// depends on mer_pkg and assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"

module mer_emit #(
   parameter int RADIUS_BITS = 10,
   parameter int COORD_BITS  = 11
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        capture,
   input  logic [COORD_BITS-1:0]       center_x,
   input  logic [COORD_BITS-1:0]       center_y,
   input  logic signed [COORD_BITS:0]  shift_x,
   input  logic signed [COORD_BITS:0]  shift_y,
   input  logic                        load,
   input  logic [RADIUS_BITS:0]        point_x,
   input  logic signed [RADIUS_BITS+1:0] point_y,
   input  logic                        point_done,
   output logic                        free,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic signed [COORD_BITS+1:0] rsp_pixel_x,
   output logic signed [COORD_BITS+1:0] rsp_pixel_y,
   output logic                        rsp_color,
   output logic                        rsp_last_of_point,
   output logic                        rsp_done_res
);

   localparam int PW = COORD_BITS + 2;

   logic signed [PW-1:0] cx_ff, cy_ff, gx_ff, gy_ff;
   logic signed [PW-1:0] xo_ff, yo_ff;
   logic                 fin_ff;
   logic                 busy_ff;
   logic [mer_pkg::PIX_CNT_W-1:0] cnt_ff;

   logic                 valid_ff;
   logic signed [PW-1:0] px_ff, py_ff;
   logic                 color_ff, last_ff, done_ff;

   logic                 step;
   logic                 sx_neg, sy_neg, green;
   logic signed [PW-1:0] base_x, base_y;
   logic signed [PW-1:0] px_in, py_in;

   always_comb begin
      step   = busy_ff && (!valid_ff || rsp_ready);
      // quadrant order: (+x,+y) (-x,+y) (-x,-y) (+x,-y), white then green
      sx_neg = cnt_ff[0] ^ cnt_ff[1];
      sy_neg = cnt_ff[1];
      green  = cnt_ff[2];
      base_x = green ? gx_ff : cx_ff;
      base_y = green ? gy_ff : cy_ff;
      px_in  = sx_neg ? base_x - xo_ff : base_x + xo_ff;
      py_in  = sy_neg ? base_y - yo_ff : base_y + yo_ff;
   end

   always_ff @(posedge clock) begin
      if (capture) begin
         cx_ff <= PW'($signed({1'b0, center_x}));
         cy_ff <= PW'($signed({1'b0, center_y}));
         gx_ff <= PW'($signed({1'b0, center_x})) + PW'(shift_x);
         gy_ff <= PW'($signed({1'b0, center_y})) + PW'(shift_y);
      end
      if (load) begin
         xo_ff  <= PW'(point_x);
         yo_ff  <= PW'(point_y);
         fin_ff <= point_done;
      end
      if (step) begin
         px_ff    <= px_in;
         py_ff    <= py_in;
         color_ff <= green ? mer_pkg::COLOR_GREEN : mer_pkg::COLOR_WHITE;
         last_ff  <= (cnt_ff == mer_pkg::PIX_LAST_IDX);
         done_ff  <= fin_ff && (cnt_ff == mer_pkg::PIX_LAST_IDX);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         cnt_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         if (load) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (step) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == mer_pkg::PIX_LAST_IDX) begin
               busy_ff <= 1'b0;
            end
         end
         if (step) begin
            valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            valid_ff <= 1'b0;
         end
      end
   end

   assign free              = !busy_ff;
   assign rsp_valid         = valid_ff;
   assign rsp_pixel_x       = px_ff;
   assign rsp_pixel_y       = py_ff;
   assign rsp_color         = color_ff;
   assign rsp_last_of_point = last_ff;
   assign rsp_done_res      = done_ff;

   `ASSERT_IMPLY(a_done_is_last, valid_ff && done_ff, last_ff, "done without last pixel")
   `ASSERT_NEXT(a_load_starts_run, load, busy_ff && (cnt_ff == '0), "point load not taken")
   `ASSERT_IMPLY(a_run_ends_on_last, $fell(busy_ff) && !$past(reset), valid_ff && last_ff,
      "run ended without eighth pixel")

endmodule

[rtl/core/mer_seq.sv]
// sequencer for the midpoint decision variable, driving one shared multiplier
// depends on mer_pkg, mer_mul and assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"

module mer_seq #(
   parameter int RADIUS_BITS = 10
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic                          req_operation,
   input  logic [RADIUS_BITS-1:0]        req_radius_x,
   input  logic [RADIUS_BITS-1:0]        req_radius_y,
   input  logic                          emit_free,
   output logic                          emit_load,
   output logic [RADIUS_BITS:0]          point_x,
   output logic signed [RADIUS_BITS+1:0] point_y,
   output logic                          point_done
);

   localparam int XW  = RADIUS_BITS + 1;
   localparam int YW  = RADIUS_BITS + 2;
   localparam int SQW = 2 * RADIUS_BITS;
   localparam int MW  = 2 * RADIUS_BITS + 3;
   localparam int PRW = 2 * MW;
   localparam int DW  = 4 * RADIUS_BITS + 8;

   typedef enum logic [4:0] {
      S_IDLE,
      S_SQX, S_SQY, S_P0A, S_P0B,
      S_T1, S_T2, S_T3,
      S_E1, S_E2, S_E3, S_E4, S_E5, S_E6, S_E7,
      S_R1A, S_R1B, S_R1C, S_R1D,
      S_R2A, S_R2B, S_R2C, S_R2D
   } state_type;

   state_type             state_ff;
   logic                  active_ff;
   logic                  region2_ff;
   logic                  flag_ff;
   logic [RADIUS_BITS-1:0] rx_ff;
   logic [XW-1:0]         x_ff;
   logic signed [YW-1:0]  y_ff;
   logic [SQW-1:0]        rxsq_ff, rysq_ff;
   logic signed [MW-1:0]  tmp_ff;
   logic signed [PRW-1:0] cmp_ff;
   logic signed [DW-1:0]  acc_ff;
   logic signed [DW-1:0]  acc_in;

   logic                  accept;
   logic signed [YW-1:0]  ym1;
   logic signed [MW-1:0]  mul_a, mul_b;
   logic signed [PRW-1:0] prod;
   logic signed [DW-1:0]  prod_w, prod2;

   mer_mul #(.W(MW)) u_mul (
      .clock (clock),
      .mul_a (mul_a),
      .mul_b (mul_b),
      .prod  (prod)
   );

   assign req_ready = (state_ff == S_IDLE) && emit_free;
   assign accept    = req_valid && req_ready;
   assign ym1       = y_ff - YW'(1);
   assign prod_w    = DW'(prod);
   assign prod2     = prod_w <<< 1;

   // operand select: one product issued per state, consumed the state after
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         S_SQX: begin
            mul_a = MW'(rx_ff);
            mul_b = MW'(rx_ff);
         end
         S_SQY: begin
            mul_a = MW'(y_ff);
            mul_b = MW'(y_ff);
         end
         S_P0A, S_T1, S_R1C, S_R2B: begin
            mul_a = MW'(rxsq_ff);
            mul_b = MW'(y_ff);
         end
         S_T2, S_E5, S_R1B, S_R2C: begin
            mul_a = MW'(rysq_ff);
            mul_b = MW'(x_ff);
         end
         S_E1: begin
            mul_a = MW'(x_ff);
            mul_b = MW'(x_ff);
         end
         S_E2: begin
            mul_a = MW'(ym1);
            mul_b = MW'(ym1);
         end
         S_E3: begin
            mul_a = prod[MW-1:0];
            mul_b = MW'(rxsq_ff);
         end
         S_E4: begin
            mul_a = tmp_ff;
            mul_b = MW'(rysq_ff);
         end
         S_E6: begin
            mul_a = MW'(rxsq_ff);
            mul_b = MW'(rysq_ff);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   // decision accumulator
   always_comb begin
      acc_in = acc_ff;
      case (state_ff)
         S_P0A:               acc_in = prod_w + DW'(rxsq_ff >> 2);
         S_P0B, S_E7:         acc_in = acc_ff - prod_w;
         S_E3:                acc_in = DW'(rysq_ff >> 2);
         S_E4, S_E5, S_E6:    acc_in = acc_ff + prod_w;
         S_R1A:               acc_in = acc_ff + DW'(rysq_ff);
         S_R1C:               acc_in = acc_ff + prod2;
         S_R1D:               acc_in = flag_ff ? acc_ff - prod2 : acc_ff;
         S_R2A:               acc_in = acc_ff + DW'(rxsq_ff);
         S_R2C:               acc_in = acc_ff - prod2;
         S_R2D:               acc_in = flag_ff ? acc_ff + prod2 : acc_ff;
         default:             acc_in = acc_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         active_ff  <= 1'b0;
         region2_ff <= 1'b0;
         flag_ff    <= 1'b0;
         acc_ff     <= '0;
         x_ff       <= '0;
         y_ff       <= '0;
      end else begin
         acc_ff <= acc_in;
         case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  if (req_operation == mer_pkg::OP_START) begin
                     rx_ff      <= req_radius_x;
                     x_ff       <= '0;
                     y_ff       <= YW'(req_radius_y);
                     region2_ff <= 1'b0;
                     active_ff  <= 1'b1;
                     state_ff   <= S_SQX;
                  end else if (active_ff) begin
                     state_ff <= region2_ff ? S_R2A : S_R1A;
                  end
               end
            end
            S_SQX: state_ff <= S_SQY;
            S_SQY: begin
               rxsq_ff  <= prod[SQW-1:0];
               state_ff <= S_P0A;
            end
            S_P0A: begin
               rysq_ff  <= prod[SQW-1:0];
               state_ff <= S_P0B;
            end
            S_P0B: state_ff <= S_T1;
            S_T1:  state_ff <= S_T2;
            S_T2: begin
               cmp_ff   <= prod;
               state_ff <= S_T3;
            end
            // region one holds while rx^2*y > ry^2*x
            S_T3:  state_ff <= (cmp_ff > prod) ? S_IDLE : S_E1;
            S_E1:  state_ff <= S_E2;
            S_E2: begin
               tmp_ff   <= prod[MW-1:0];
               state_ff <= S_E3;
            end
            S_E3:  state_ff <= S_E4;
            S_E4:  state_ff <= S_E5;
            S_E5:  state_ff <= S_E6;
            S_E6:  state_ff <= S_E7;
            S_E7: begin
               region2_ff <= 1'b1;
               state_ff   <= S_IDLE;
            end
            S_R1A: begin
               x_ff <= x_ff + 1'b1;
               if (!acc_ff[DW-1]) begin
                  y_ff    <= ym1;
                  flag_ff <= 1'b1;
               end else begin
                  flag_ff <= 1'b0;
               end
               state_ff <= S_R1B;
            end
            S_R1B: state_ff <= S_R1C;
            S_R1C: state_ff <= S_R1D;
            S_R1D: state_ff <= S_T1;
            S_R2A: begin
               y_ff <= ym1;
               if (acc_ff[DW-1] || (acc_ff == '0)) begin
                  x_ff    <= x_ff + 1'b1;
                  flag_ff <= 1'b1;
               end else begin
                  flag_ff <= 1'b0;
               end
               // stepping below row zero ends the ellipse
               if (ym1[YW-1]) begin
                  active_ff <= 1'b0;
               end
               state_ff <= S_R2B;
            end
            S_R2B: state_ff <= S_R2C;
            S_R2C: state_ff <= S_R2D;
            S_R2D: state_ff <= S_IDLE;
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign emit_load  = accept && (req_operation == mer_pkg::OP_ADVANCE) && active_ff;
   assign point_x    = x_ff;
   assign point_y    = y_ff;
   assign point_done = region2_ff && (y_ff == '0);

   `ASSERT_NEXT(a_load_blocks_req, emit_load, !req_ready, "ready while a point is stepping")
   `ASSERT_IMPLY(a_row_nonneg, (state_ff == S_IDLE) && active_ff, !y_ff[YW-1],
      "active ellipse with negative row")
   `ASSERT_NEXT(a_entry_sets_region, state_ff == S_E7,
      region2_ff && active_ff && (state_ff == S_IDLE), "region two entry not recorded")

endmodule

[rtl/core/midpoint_ellipse_rasterizer_top.sv]
// top level of the midpoint ellipse rasterizer
// depends on mer_pkg, mer_seq (with mer_mul) and mer_emit
`timescale 1ns / 1ps

// Usage:
//   req channel (valid/ready): operation 0 starts an ellipse from radius_x/y,
//   center_x/y and shift_x/y; operation 1 advances to the next point.
//   rsp channel (valid/ready): eight pixels per advance, one transaction each,
//   four white about the center then four green about center plus shift;
//   last_of_point marks the eighth, done_res also marks the ellipse's final one.
//   A start produces no pixels and also runs the region two entry when region two
//   begins at once; an advance while no ellipse is active is taken and dropped.
//   An accepted advance loads the emitter, which then registers the first pixel.
//   Per advance the decision update runs on the single shared multiplier,
//   through R2A to R2D in region two, or R1A to R1D and the region test T1 to T3
//   in region one, plus E1 to E7 when crossing into region two; the eight pixels
//   drain in parallel at one per cycle while the receiver is ready.
//   req_ready stays low while the sequencer runs or the emitter is still stepping pixels;
//   a stalled receiver holds the pixel in the output register and the block
//   waits. Synchronous reset returns to idle with no ellipse active.
module midpoint_ellipse_rasterizer_top #(
   parameter int RADIUS_BITS = 10,
   parameter int COORD_BITS  = 11
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic                         req_operation,
   input  logic [RADIUS_BITS-1:0]       req_radius_x,
   input  logic [RADIUS_BITS-1:0]       req_radius_y,
   input  logic [COORD_BITS-1:0]        req_center_x,
   input  logic [COORD_BITS-1:0]        req_center_y,
   input  logic signed [COORD_BITS:0]   req_shift_x,
   input  logic signed [COORD_BITS:0]   req_shift_y,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic signed [COORD_BITS+1:0] rsp_pixel_x,
   output logic signed [COORD_BITS+1:0] rsp_pixel_y,
   output logic                         rsp_color,
   output logic                         rsp_last_of_point,
   output logic                         rsp_done_res
);

   logic                          emit_free;
   logic                          emit_load;
   logic                          capture;
   logic [RADIUS_BITS:0]          point_x;
   logic signed [RADIUS_BITS+1:0] point_y;
   logic                          point_done;

   assign capture = req_valid && req_ready && (req_operation == mer_pkg::OP_START);

   mer_seq #(.RADIUS_BITS(RADIUS_BITS)) u_seq (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_operation (req_operation),
      .req_radius_x  (req_radius_x),
      .req_radius_y  (req_radius_y),
      .emit_free     (emit_free),
      .emit_load     (emit_load),
      .point_x       (point_x),
      .point_y       (point_y),
      .point_done    (point_done)
   );

   mer_emit #(.RADIUS_BITS(RADIUS_BITS), .COORD_BITS(COORD_BITS)) u_emit (
      .clock             (clock),
      .reset             (reset),
      .capture           (capture),
      .center_x          (req_center_x),
      .center_y          (req_center_y),
      .shift_x           (req_shift_x),
      .shift_y           (req_shift_y),
      .load              (emit_load),
      .point_x           (point_x),
      .point_y           (point_y),
      .point_done        (point_done),
      .free              (emit_free),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_pixel_x       (rsp_pixel_x),
      .rsp_pixel_y       (rsp_pixel_y),
      .rsp_color         (rsp_color),
      .rsp_last_of_point (rsp_last_of_point),
      .rsp_done_res      (rsp_done_res)
   );

endmodule

[dv/midpoint_ellipse_rasterizer_top_tb.sv]
// self-checking testbench for the midpoint ellipse rasterizer top level
// depends on mer_pkg and midpoint_ellipse_rasterizer_top; predicts every pixel in-line
`timescale 1ns / 1ps

module midpoint_ellipse_rasterizer_top_tb;

   localparam int RADIUS_BITS    = 10;
   localparam int COORD_BITS     = 11;
   localparam int PIX_W          = COORD_BITS + 2;
   localparam int HOLD_CYCLES    = 300;
   localparam int WATCHDOG_LIMIT = 3000;
   localparam int TAIL_CYCLES    = 40;

   typedef struct packed {
      logic [PIX_W-1:0] x;
      logic [PIX_W-1:0] y;
      logic             color;
      logic             last;
      logic             done;
   } pixel_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                         req_valid     = 1'b0;
   logic                         req_ready;
   logic                         req_operation = mer_pkg::OP_START;
   logic [RADIUS_BITS-1:0]       req_radius_x  = '0;
   logic [RADIUS_BITS-1:0]       req_radius_y  = '0;
   logic [COORD_BITS-1:0]        req_center_x  = '0;
   logic [COORD_BITS-1:0]        req_center_y  = '0;
   logic signed [COORD_BITS:0]   req_shift_x   = '0;
   logic signed [COORD_BITS:0]   req_shift_y   = '0;
   logic                         rsp_valid;
   logic                         rsp_ready     = 1'b0;
   logic signed [COORD_BITS+1:0] rsp_pixel_x;
   logic signed [COORD_BITS+1:0] rsp_pixel_y;
   logic                         rsp_color;
   logic                         rsp_last_of_point;
   logic                         rsp_done_res;

   midpoint_ellipse_rasterizer_top #(
      .RADIUS_BITS(RADIUS_BITS),
      .COORD_BITS (COORD_BITS)
   ) i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_operation    (req_operation),
      .req_radius_x     (req_radius_x),
      .req_radius_y     (req_radius_y),
      .req_center_x     (req_center_x),
      .req_center_y     (req_center_y),
      .req_shift_x      (req_shift_x),
      .req_shift_y      (req_shift_y),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_pixel_x      (rsp_pixel_x),
      .rsp_pixel_y      (rsp_pixel_y),
      .rsp_color        (rsp_color),
      .rsp_last_of_point(rsp_last_of_point),
      .rsp_done_res     (rsp_done_res)
   );

   always #1 clock = ~clock;

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
   end

   // ellipse tracer state
   bit     ell_active  = 1'b0;
   bit     ell_region2 = 1'b0;
   longint point_x     = 0;
   longint point_y     = 0;
   longint decision_var = 0;
   longint rx_sq       = 0;
   longint ry_sq       = 0;
   longint center_col  = 0;
   longint center_row  = 0;
   longint shift_col   = 0;
   longint shift_row   = 0;

   pixel_type pending_pixels[$];
   int     error_count   = 0;
   int     send_idle_pct = 0;
   int     recv_idle_pct = 0;
   int     hold_token    = 0;
   int     hold_seen     = 0;
   int     hold_left     = 0;
   int     stall_cycles  = 0;

   task automatic push_pixel(input longint px, input longint py, input logic color,
                             input logic last, input logic done);
      pixel_type pix;
      pix.x     = px[PIX_W-1:0];
      pix.y     = py[PIX_W-1:0];
      pix.color = color;
      pix.last  = last;
      pix.done  = done;
      pending_pixels.push_back(pix);
   endtask

   function automatic bit region_one_test();
      return rx_sq * point_y > ry_sq * point_x;
   endfunction

   task automatic enter_region_two();
      longint ym1;
      ym1          = point_y - 1;
      ell_region2  = 1'b1;
      decision_var = ry_sq * point_x * point_x + ry_sq * point_x + (ry_sq >>> 2)
                   + rx_sq * ym1 * ym1 - rx_sq * ry_sq;
   endtask

   // one accepted transaction on the request channel
   task automatic trace_ellipse_step(input logic op, input logic [RADIUS_BITS-1:0] rx,
                                     input logic [RADIUS_BITS-1:0] ry,
                                     input logic [COORD_BITS-1:0] cx,
                                     input logic [COORD_BITS-1:0] cy,
                                     input logic signed [COORD_BITS:0] sx,
                                     input logic signed [COORD_BITS:0] sy);
      longint x0, y0, gx, gy;
      bit     finished;
      if (op == mer_pkg::OP_START) begin
         center_col   = longint'(cx);
         center_row   = longint'(cy);
         shift_col    = longint'(sx);
         shift_row    = longint'(sy);
         rx_sq        = longint'(rx) * longint'(rx);
         ry_sq        = longint'(ry) * longint'(ry);
         point_x      = 0;
         point_y      = longint'(ry);
         decision_var = ry_sq + (rx_sq >>> 2) - rx_sq * longint'(ry);
         ell_region2  = 1'b0;
         ell_active   = 1'b1;
         // a zero radius fails the region one test right away
         if (!region_one_test()) enter_region_two();
      end else if (ell_active) begin
         x0       = point_x;
         y0       = point_y;
         finished = 1'b0;
         if (!ell_region2) begin
            point_x = point_x + 1;
            if (decision_var >= 0) begin
               point_y      = point_y - 1;
               decision_var = decision_var + 2 * ry_sq * point_x - 2 * rx_sq * point_y + ry_sq;
            end else begin
               decision_var = decision_var + 2 * ry_sq * point_x + ry_sq;
            end
            if (!region_one_test()) enter_region_two();
         end else begin
            point_y = point_y - 1;
            if (decision_var <= 0) begin
               point_x      = point_x + 1;
               decision_var = decision_var + 2 * ry_sq * point_x - 2 * rx_sq * point_y + rx_sq;
            end else begin
               decision_var = decision_var + rx_sq - 2 * rx_sq * point_y;
            end
            if (point_y < 0) begin
               finished   = 1'b1;
               ell_active = 1'b0;
            end
         end
         gx = center_col + shift_col;
         gy = center_row + shift_row;
         push_pixel(center_col + x0, center_row + y0, mer_pkg::COLOR_WHITE, 1'b0, 1'b0);
         push_pixel(center_col - x0, center_row + y0, mer_pkg::COLOR_WHITE, 1'b0, 1'b0);
         push_pixel(center_col - x0, center_row - y0, mer_pkg::COLOR_WHITE, 1'b0, 1'b0);
         push_pixel(center_col + x0, center_row - y0, mer_pkg::COLOR_WHITE, 1'b0, 1'b0);
         push_pixel(gx + x0, gy + y0, mer_pkg::COLOR_GREEN, 1'b0, 1'b0);
         push_pixel(gx - x0, gy + y0, mer_pkg::COLOR_GREEN, 1'b0, 1'b0);
         push_pixel(gx - x0, gy - y0, mer_pkg::COLOR_GREEN, 1'b0, 1'b0);
         push_pixel(gx + x0, gy - y0, mer_pkg::COLOR_GREEN, 1'b1, finished);
      end
   endtask

   // valid is left high after acceptance; release_request lowers it, as does the next call when it idles
   task automatic send_request(input logic op, input logic [RADIUS_BITS-1:0] rx,
                               input logic [RADIUS_BITS-1:0] ry,
                               input logic [COORD_BITS-1:0] cx,
                               input logic [COORD_BITS-1:0] cy,
                               input logic signed [COORD_BITS:0] sx,
                               input logic signed [COORD_BITS:0] sy);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_valid     <= 1'b1;
      req_operation <= op;
      req_radius_x  <= rx;
      req_radius_y  <= ry;
      req_center_x  <= cx;
      req_center_y  <= cy;
      req_shift_x   <= sx;
      req_shift_y   <= sy;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      trace_ellipse_step(op, rx, ry, cx, cy, sx, sy);
   endtask

   task automatic send_start(input logic [RADIUS_BITS-1:0] rx, input logic [RADIUS_BITS-1:0] ry,
                             input logic [COORD_BITS-1:0] cx, input logic [COORD_BITS-1:0] cy,
                             input logic signed [COORD_BITS:0] sx,
                             input logic signed [COORD_BITS:0] sy);
      send_request(mer_pkg::OP_START, rx, ry, cx, cy, sx, sy);
   endtask

   // fields are ignored on advance but still toggled
   task automatic send_advance();
      send_request(mer_pkg::OP_ADVANCE, RADIUS_BITS'($urandom_range(1023, 0)),
                   RADIUS_BITS'($urandom_range(1023, 0)),
                   COORD_BITS'($urandom_range(2047, 0)), COORD_BITS'($urandom_range(2047, 0)),
                   (COORD_BITS + 1)'($urandom_range(4095, 0)),
                   (COORD_BITS + 1)'($urandom_range(4095, 0)));
   endtask

   task automatic release_request();
      req_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic wait_for_drain();
      while (pending_pixels.size() != 0) @(posedge clock);
   endtask

   task automatic report_mismatch(input string what);
      $display("ERROR at %0t: %s", $realtime, what);
      error_count++;
   endtask

   task automatic check_pixel();
      pixel_type want;
      if (pending_pixels.size() == 0) begin
         report_mismatch($sformatf("unexpected pixel x=%0d y=%0d", rsp_pixel_x, rsp_pixel_y));
      end else begin
         want = pending_pixels.pop_front();
         if (rsp_pixel_x !== want.x)
            report_mismatch($sformatf("pixel_x got %0d want %0d", rsp_pixel_x, $signed(want.x)));
         if (rsp_pixel_y !== want.y)
            report_mismatch($sformatf("pixel_y got %0d want %0d", rsp_pixel_y, $signed(want.y)));
         if (rsp_color !== want.color)
            report_mismatch($sformatf("color got %0b want %0b", rsp_color, want.color));
         if (rsp_last_of_point !== want.last)
            report_mismatch($sformatf("last_of_point got %0b want %0b", rsp_last_of_point,
                                      want.last));
         if (rsp_done_res !== want.done)
            report_mismatch($sformatf("done_res got %0b want %0b", rsp_done_res, want.done));
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) check_pixel();
   end

   // receiver: random stalls, plus a long hold-off when the test asks for one
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_seen != hold_token) begin
         hold_seen <= hold_token;
         hold_left <= HOLD_CYCLES;
         rsp_ready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= WATCHDOG_LIMIT) begin
         $display("FAIL");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   task automatic test_directed_cases();
      send_advance();                                   // no ellipse yet, dropped
      send_start(10'd0, 10'd0, 11'd0, 11'd0, 12'h000, 12'h000);
      send_advance();                                   // degenerate point ends at once
      send_advance();
      // zero width, goes to region two
      send_start(10'd0, 10'd3, 11'd2047, 11'd2047, 12'h7ff, 12'h7ff);
      while (ell_active) send_advance();
      // zero height, negative wrap
      send_start(10'd3, 10'd0, 11'd0, 11'd0, 12'h800, 12'h800);
      send_advance();
      send_start(10'd1023, 10'd1023, 11'd1024, 11'd1024, 12'h000, 12'h000);
      repeat (2) send_advance();
      // restart mid-ellipse
      send_start(10'd1023, 10'd1, 11'd2047, 11'd0, 12'h7ff, 12'h800);
      repeat (3) send_advance();
      send_start(10'd1, 10'd1023, 11'd0, 11'd2047, 12'h800, 12'h7ff);
      repeat (2) send_advance();
      send_start(10'd2, 10'd2, 11'd5, 11'd5, 12'hffd, 12'h003);
      while (ell_active) send_advance();
      release_request();
   endtask

   task automatic test_random_ellipses(input int item_goal);
      int taken;
      int kind;
      int cap;
      bit big;
      logic [RADIUS_BITS-1:0] rx, ry;
      taken = 0;
      while (taken < item_goal) begin
         kind = $urandom_range(99);
         if (kind < 6) begin
            // stray advance, often on an idle block
            if (ell_active) taken++;
            send_advance();
         end else begin
            big = (kind >= 88);
            rx  = big ? RADIUS_BITS'($urandom_range(1023, 0)) : RADIUS_BITS'($urandom_range(7, 0));
            ry  = big ? RADIUS_BITS'($urandom_range(1023, 0)) : RADIUS_BITS'($urandom_range(7, 0));
            send_start(rx, ry, COORD_BITS'($urandom_range(2047, 0)),
                       COORD_BITS'($urandom_range(2047, 0)),
                       (COORD_BITS + 1)'($urandom_range(4095, 0)),
                       (COORD_BITS + 1)'($urandom_range(4095, 0)));
            taken++;
            // big ellipses and some small ones are cut short by the next start
            if (big) cap = $urandom_range(5, 1);
            else if ($urandom_range(9) == 0) cap = $urandom_range(3, 1);
            else cap = 1 << 20;
            while (ell_active && cap > 0) begin
               send_advance();
               taken++;
               cap--;
            end
         end
      end
      release_request();
   endtask

   task automatic test_output_backpressure();
      send_start(10'd9, 10'd9, 11'd1000, 11'd1000, -12'sd5, 12'sd7);
      hold_token++;
      // keep offering advances while the receiver holds off
      repeat (8) send_advance();
      release_request();
      wait_for_drain();
      while (ell_active) send_advance();
      release_request();
   endtask

   initial begin
      wait (reset == 1'b0);
      @(posedge clock);
      send_idle_pct = 13;
      recv_idle_pct = 58;
      test_directed_cases();
      test_random_ellipses(70);
      send_idle_pct = 58;
      recv_idle_pct = 13;
      test_random_ellipses(70);
      test_output_backpressure();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_random_ellipses(70);
      wait_for_drain();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

[midpoint_ellipse_rasterizer_top.f]
+incdir+rtl/core
rtl/core/mer_pkg.sv
rtl/core/mer_mul.sv
rtl/core/mer_emit.sv
rtl/core/mer_seq.sv
rtl/core/midpoint_ellipse_rasterizer_top.sv
dv/midpoint_ellipse_rasterizer_top_tb.sv
